### sv/r2y420_pkg.sv
package r2y420_pkg;

    // Pixel channel and fixed point widths.
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned ACC_W   = 26;
    localparam int unsigned PAIR_W  = 9;

    // Width in use after reset.
    localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd640;

    // Decoupling queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // BT.601 full range coefficients, scaled by 2^16.
    localparam logic [15:0] Y_R  = 16'd19595;
    localparam logic [15:0] Y_G  = 16'd38470;
    localparam logic [15:0] Y_B  = 16'd7471;
    localparam logic [15:0] CB_R = 16'd11058;
    localparam logic [15:0] CB_G = 16'd21710;
    localparam logic [15:0] CB_B = 16'd32768;
    localparam logic [15:0] CR_R = 16'd32768;
    localparam logic [15:0] CR_G = 16'd27439;
    localparam logic [15:0] CR_B = 16'd5329;

    // Chroma offset of 128 in the same scale.
    localparam logic signed [ACC_W-1:0] CHROMA_OFS = 26'sd8388608;

    // One pixel as classified by the front.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             col_odd;
        logic             row_odd;
    } t_pix_class;

    // Truncate a 16-bit fraction accumulator and clamp it to a byte.
    function automatic logic [PIX_W-1:0] fix_to_byte(input logic signed [ACC_W-1:0] acc);
        logic [PIX_W-1:0] res;
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (acc[ACC_W-2]) begin
            res = '1;
        end else begin
            res = acc[23:16];
        end
        return res;
    endfunction

endpackage

### sv/r2y420_queue.sv
module r2y420_queue #(
    parameter int unsigned DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty,
    output logic              o_full
);

    logic [DATA_W-1:0] r_mem [r2y420_pkg::QUEUE_DEPTH];
    logic [r2y420_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [r2y420_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [r2y420_pkg::QCNT_W-1:0] r_count, n_count;
    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == r2y420_pkg::QCNT_W'(r2y420_pkg::QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### sv/r2y420_front.sv
module r2y420_front #(
    parameter int unsigned MAX_WIDTH = 2048,
    parameter int unsigned COL_W     = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [3*r2y420_pkg::PIX_W-1:0] i_pixel,
    input  logic                         i_frame_start,
    input  logic [r2y420_pkg::CFG_W-1:0] i_frame_width,
    input  logic                         i_queue_full,
    output logic                         o_ready,
    output logic                         o_push,
    output r2y420_pkg::t_pix_class       o_item,
    output logic [COL_W-2:0]             o_pair_idx
);

    localparam int unsigned CMP_W = (COL_W + 1 > r2y420_pkg::CFG_W) ?
                                    COL_W + 1 : r2y420_pkg::CFG_W;

    logic [COL_W-1:0] r_col, n_col;
    logic             r_row_odd, n_row_odd;
    logic [COL_W-1:0] col_cur;
    logic             row_cur;
    logic [CMP_W-1:0] col_plus;
    logic             row_end;

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && o_ready;

    // Position of the current pixel; a frame start puts it at row 0, column 0.
    assign col_cur  = i_frame_start ? '0 : r_col;
    assign row_cur  = i_frame_start ? 1'b0 : r_row_odd;
    assign col_plus = CMP_W'(col_cur) + 1'b1;
    assign row_end  = (col_plus >= CMP_W'(i_frame_width)) ||
                      (col_plus >= CMP_W'(MAX_WIDTH));

    // Classify the pixel for the back.
    always_comb begin
        o_item.red     = i_pixel[r2y420_pkg::PIX_W-1:0];
        o_item.green   = i_pixel[2*r2y420_pkg::PIX_W-1:r2y420_pkg::PIX_W];
        o_item.blue    = i_pixel[3*r2y420_pkg::PIX_W-1:2*r2y420_pkg::PIX_W];
        o_item.col_odd = col_cur[0];
        o_item.row_odd = row_cur;
        o_pair_idx     = col_cur[COL_W-1:1];
    end

    // Advance the raster position on each accepted beat.
    always_comb begin
        n_col     = r_col;
        n_row_odd = r_row_odd;
        if (o_push) begin
            if (row_end) begin
                n_col     = '0;
                n_row_odd = !row_cur;
            end else begin
                n_col     = col_plus[COL_W-1:0];
                n_row_odd = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row_odd <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row_odd <= n_row_odd;
        end
    end

endmodule

### sv/r2y420_back.sv
module r2y420_back #(
    parameter int unsigned MAX_WIDTH = 2048,
    parameter int unsigned COL_W     = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  r2y420_pkg::t_pix_class       i_item,
    input  logic [COL_W-2:0]             i_pair_idx,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [r2y420_pkg::PIX_W-1:0] o_luma,
    output logic                         o_chroma_valid,
    output logic [r2y420_pkg::PIX_W-1:0] o_blue_difference,
    output logic [r2y420_pkg::PIX_W-1:0] o_red_difference
);

    localparam int unsigned LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int unsigned IDX_W      = COL_W - 1;
    localparam int unsigned PIX_W      = r2y420_pkg::PIX_W;
    localparam int unsigned PAIR_W     = r2y420_pkg::PAIR_W;
    localparam int unsigned ACC_W      = r2y420_pkg::ACC_W;

    logic en;

    // Stage A: accumulators.
    logic                    r_a_vld;
    logic signed [ACC_W-1:0] r_a_y, r_a_cb, r_a_cr;
    logic                    r_a_col_odd, r_a_row_odd;
    logic [IDX_W-1:0]        r_a_idx;

    // Stage B: bytes, pair sums and line store read.
    logic                    r_b_vld;
    logic [PIX_W-1:0]        r_b_y;
    logic                    r_b_chroma;
    logic [PAIR_W-1:0]       r_b_scb, r_b_scr;
    logic [2*PAIR_W-1:0]     r_line_q;
    logic [PIX_W-1:0]        r_pend_cb, r_pend_cr;

    // Output register.
    logic                    r_o_vld;
    logic [PIX_W-1:0]        r_o_y, r_o_cb, r_o_cr;
    logic                    r_o_chroma;

    // Line store of even-row pair sums: Cb sum high, Cr sum low.
    logic [2*PAIR_W-1:0]     r_line [LINE_DEPTH];

    logic [23:0]             p_y_r, p_y_g, p_y_b;
    logic [23:0]             p_cb_r, p_cb_g, p_cb_b;
    logic [23:0]             p_cr_r, p_cr_g, p_cr_b;
    logic [PIX_W-1:0]        a_y, a_cb, a_cr;
    logic [PAIR_W-1:0]       a_scb, a_scr;
    logic [PAIR_W:0]         o_sum_cb, o_sum_cr;

    // The whole back moves when the output register is free or being taken.
    assign en      = !r_o_vld || i_ready;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_o_vld;

    // Constant multiplies of the color matrix.
    always_comb begin
        p_y_r  = 24'(r2y420_pkg::Y_R)  * 24'(i_item.red);
        p_y_g  = 24'(r2y420_pkg::Y_G)  * 24'(i_item.green);
        p_y_b  = 24'(r2y420_pkg::Y_B)  * 24'(i_item.blue);
        p_cb_r = 24'(r2y420_pkg::CB_R) * 24'(i_item.red);
        p_cb_g = 24'(r2y420_pkg::CB_G) * 24'(i_item.green);
        p_cb_b = 24'(r2y420_pkg::CB_B) * 24'(i_item.blue);
        p_cr_r = 24'(r2y420_pkg::CR_R) * 24'(i_item.red);
        p_cr_g = 24'(r2y420_pkg::CR_G) * 24'(i_item.green);
        p_cr_b = 24'(r2y420_pkg::CR_B) * 24'(i_item.blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_y       <= $signed({2'b00, p_y_r}) + $signed({2'b00, p_y_g}) +
                           $signed({2'b00, p_y_b});
            r_a_cb      <= r2y420_pkg::CHROMA_OFS + $signed({2'b00, p_cb_b}) -
                           $signed({2'b00, p_cb_r}) - $signed({2'b00, p_cb_g});
            r_a_cr      <= r2y420_pkg::CHROMA_OFS + $signed({2'b00, p_cr_r}) -
                           $signed({2'b00, p_cr_g}) - $signed({2'b00, p_cr_b});
            r_a_col_odd <= i_item.col_odd;
            r_a_row_odd <= i_item.row_odd;
            r_a_idx     <= i_pair_idx;
        end
    end

    // Truncate, clamp and form the horizontal pair sums.
    assign a_y   = r2y420_pkg::fix_to_byte(r_a_y);
    assign a_cb  = r2y420_pkg::fix_to_byte(r_a_cb);
    assign a_cr  = r2y420_pkg::fix_to_byte(r_a_cr);
    assign a_scb = PAIR_W'(r_pend_cb) + PAIR_W'(a_cb);
    assign a_scr = PAIR_W'(r_pend_cr) + PAIR_W'(a_cr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld    <= 1'b0;
            r_b_chroma <= 1'b0;
            r_pend_cb  <= '0;
            r_pend_cr  <= '0;
        end else if (en) begin
            r_b_vld    <= r_a_vld;
            r_b_chroma <= r_a_vld && r_a_col_odd && r_a_row_odd;
            if (r_a_vld && !r_a_col_odd) begin
                r_pend_cb <= a_cb;
                r_pend_cr <= a_cr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_y   <= a_y;
            r_b_scb <= a_scb;
            r_b_scr <= a_scr;
        end
    end

    // Line store: even rows write the pair sums, odd rows read them back.
    always_ff @(posedge i_clk) begin
        if (en && r_a_vld && r_a_col_odd) begin
            if (r_a_row_odd) begin
                r_line_q <= r_line[r_a_idx];
            end else begin
                r_line[r_a_idx] <= {a_scb, a_scr};
            end
        end
    end

    // Average the 2x2 block as floor of sum / 4.
    assign o_sum_cb = (PAIR_W + 1)'(r_line_q[2*PAIR_W-1:PAIR_W]) + (PAIR_W + 1)'(r_b_scb);
    assign o_sum_cr = (PAIR_W + 1)'(r_line_q[PAIR_W-1:0]) + (PAIR_W + 1)'(r_b_scr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_y      <= r_b_y;
            r_o_chroma <= r_b_chroma;
            r_o_cb     <= r_b_chroma ? o_sum_cb[PAIR_W:2] : '0;
            r_o_cr     <= r_b_chroma ? o_sum_cr[PAIR_W:2] : '0;
        end
    end

    assign o_luma            = r_o_y;
    assign o_chroma_valid    = r_o_chroma;
    assign o_blue_difference = r_o_cb;
    assign o_red_difference  = r_o_cr;

endmodule

### sv/rgb_to_yuv420_converter.sv
// RGB to YCbCr 4:2:0 converter (BT.601, full range). Pixels arrive in raster
// order on the slave stream, one 8-bit RGB pixel per beat, with tuser marking
// the first pixel of a frame. Every pixel gives one result beat carrying its
// luma; at each pixel in an odd row and an odd column the beat also carries
// the Cb and Cr averaged over the 2x2 block it completes, flagged in tuser.
// The block takes one pixel per clock while the output is not stalled; each
// pixel passes through the classifying front and its four-entry queue, then
// three back stages (color matrix, clamp with line store access, block average
// into the output register). The line
// store holds (MAX_WIDTH+1)/2 pair sums in a single-port memory, written by even
// rows and read by odd rows. Write frame_width only while the block is idle;
// a value above MAX_WIDTH acts as MAX_WIDTH.
module rgb_to_yuv420_converter #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: frame_width.
    input  logic        i_cfg_wr_en,
    input  logic [11:0] i_cfg_wr_data,
    // Pixel input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        i_s_tuser,   // frame_start
    // Result output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // luma [7:0], blue_difference [15:8],
                                     // red_difference [23:16]
    output logic        o_m_tuser    // chroma_valid
);

    localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
    localparam int unsigned IDX_W  = COL_W - 1;
    localparam int unsigned ITEM_W = $bits(r2y420_pkg::t_pix_class) + IDX_W;

    logic [r2y420_pkg::CFG_W-1:0] r_frame_width;
    logic                         queue_full;
    logic                         queue_empty;
    logic                         push;
    logic                         pop;
    r2y420_pkg::t_pix_class       front_item;
    logic [IDX_W-1:0]             front_idx;
    logic [ITEM_W-1:0]            queue_out;
    r2y420_pkg::t_pix_class       back_item;
    logic [IDX_W-1:0]             back_idx;

    // Frame width register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= r2y420_pkg::WIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_frame_width <= i_cfg_wr_data;
        end
    end

    r2y420_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .i_pixel       (i_s_tdata),
        .i_frame_start (i_s_tuser),
        .i_frame_width (r_frame_width),
        .i_queue_full  (queue_full),
        .o_ready       (o_s_tready),
        .o_push        (push),
        .o_item        (front_item),
        .o_pair_idx    (front_idx)
    );

    r2y420_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_item, front_idx}),
        .i_pop   (pop),
        .o_data  (queue_out),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    assign back_item = queue_out[ITEM_W-1:IDX_W];
    assign back_idx  = queue_out[IDX_W-1:0];

    r2y420_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (queue_empty),
        .i_item            (back_item),
        .i_pair_idx        (back_idx),
        .o_pop             (pop),
        .o_valid           (o_m_tvalid),
        .i_ready           (i_m_tready),
        .o_luma            (o_m_tdata[7:0]),
        .o_chroma_valid    (o_m_tuser),
        .o_blue_difference (o_m_tdata[15:8]),
        .o_red_difference  (o_m_tdata[23:16])
    );

endmodule
